/* src/desch_pkg.sv */
// Shared types, codes and defaults for the elevator disk request scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package desch_pkg;

   localparam int DEF_TABLE_DEPTH  = 16;
   localparam int DEF_MAX_CYLINDER = 199;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_SCHED = 1'b1;

   localparam logic [1:0] STATUS_STORED = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_SERVED = 2'd2;
   localparam logic [1:0] STATUS_EMPTY  = 2'd3;

   typedef struct packed {
      logic [7:0] id;
      logic [7:0] cylinder;
      logic [7:0] track;
      logic [7:0] record;
   } entry_type;

   typedef struct packed {
      logic start;
      logic sample;
   } scan_ctl_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_SHIFT  = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

endpackage

`default_nettype wire

/* src/desch_table.sv */
// Pending request table: one write port and one registered read port.
// Depends on desch_pkg for the entry layout.
`default_nettype none

module desch_table #(
   parameter int TABLE_DEPTH = desch_pkg::DEF_TABLE_DEPTH,
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [IDX_W-1:0]         wr_addr,
   input  desch_pkg::entry_type    wr_data,
   input  wire [IDX_W-1:0]         rd_addr,
   output desch_pkg::entry_type    rd_data_ff
);
   import desch_pkg::*;

   entry_type mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* src/desch_select.sv */
// Shared compare unit that sees one table entry per cycle and keeps the best
// candidate on the head cylinder, above it and below it. Depends on desch_pkg.
`default_nettype none

module desch_select #(
   parameter int TABLE_DEPTH = desch_pkg::DEF_TABLE_DEPTH,
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  wire                     clock,
   input  wire                     reset,
   input  desch_pkg::scan_ctl_type scan_ctl,
   input  desch_pkg::entry_type    smp_entry,
   input  wire [IDX_W-1:0]         smp_idx,
   input  wire [7:0]               head_cylinder,
   input  wire [7:0]               head_track,
   input  wire [7:0]               head_record,
   input  wire                     sweep_down,
   output desch_pkg::entry_type    pick_entry,
   output logic [IDX_W-1:0]        pick_idx,
   output logic                    pick_down
);
   import desch_pkg::*;

   logic             on_found_ff, on_found_in;
   logic             up_found_ff, up_found_in;
   logic             dn_found_ff, dn_found_in;
   entry_type        on_ent_ff, on_ent_in;
   entry_type        up_ent_ff, up_ent_in;
   entry_type        dn_ent_ff, dn_ent_in;
   logic [IDX_W-1:0] on_idx_ff, on_idx_in;
   logic [IDX_W-1:0] up_idx_ff, up_idx_in;
   logic [IDX_W-1:0] dn_idx_ff, dn_idx_in;
   logic [8:0]       on_dist_ff, on_dist_in;

   logic [7:0] trk_diff;
   logic [7:0] rec_diff;
   logic [8:0] cand_dist;

   assign trk_diff = (smp_entry.track > head_track) ? smp_entry.track - head_track
                                                    : head_track - smp_entry.track;
   assign rec_diff = (smp_entry.record > head_record) ? smp_entry.record - head_record
                                                      : head_record - smp_entry.record;
   assign cand_dist = {1'b0, trk_diff} + {1'b0, rec_diff};

   always_comb begin
      on_found_in = on_found_ff;
      up_found_in = up_found_ff;
      dn_found_in = dn_found_ff;
      on_ent_in   = on_ent_ff;
      up_ent_in   = up_ent_ff;
      dn_ent_in   = dn_ent_ff;
      on_idx_in   = on_idx_ff;
      up_idx_in   = up_idx_ff;
      dn_idx_in   = dn_idx_ff;
      on_dist_in  = on_dist_ff;
      if (scan_ctl.start) begin
         on_found_in = 1'b0;
         up_found_in = 1'b0;
         dn_found_in = 1'b0;
      end else if (scan_ctl.sample) begin
         // Strict compares keep the earliest entry on ties.
         if (smp_entry.cylinder == head_cylinder) begin
            if (!on_found_ff || cand_dist < on_dist_ff) begin
               on_found_in = 1'b1;
               on_ent_in   = smp_entry;
               on_idx_in   = smp_idx;
               on_dist_in  = cand_dist;
            end
         end else if (smp_entry.cylinder > head_cylinder) begin
            if (!up_found_ff || smp_entry.cylinder < up_ent_ff.cylinder) begin
               up_found_in = 1'b1;
               up_ent_in   = smp_entry;
               up_idx_in   = smp_idx;
            end
         end else begin
            if (!dn_found_ff || smp_entry.cylinder > dn_ent_ff.cylinder) begin
               dn_found_in = 1'b1;
               dn_ent_in   = smp_entry;
               dn_idx_in   = smp_idx;
            end
         end
      end
   end

   always_comb begin
      pick_entry = on_ent_ff;
      pick_idx   = on_idx_ff;
      pick_down  = sweep_down;
      if (!on_found_ff) begin
         if (!sweep_down) begin
            if (up_found_ff) begin
               pick_entry = up_ent_ff;
               pick_idx   = up_idx_ff;
               pick_down  = 1'b0;
            end else begin
               pick_entry = dn_ent_ff;
               pick_idx   = dn_idx_ff;
               pick_down  = 1'b1;
            end
         end else begin
            if (dn_found_ff) begin
               pick_entry = dn_ent_ff;
               pick_idx   = dn_idx_ff;
               pick_down  = 1'b1;
            end else begin
               pick_entry = up_ent_ff;
               pick_idx   = up_idx_ff;
               pick_down  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_found_ff <= 1'b0;
         up_found_ff <= 1'b0;
         dn_found_ff <= 1'b0;
      end else begin
         on_found_ff <= on_found_in;
         up_found_ff <= up_found_in;
         dn_found_ff <= dn_found_in;
      end
      on_ent_ff  <= on_ent_in;
      up_ent_ff  <= up_ent_in;
      dn_ent_ff  <= dn_ent_in;
      on_idx_ff  <= on_idx_in;
      up_idx_ff  <= up_idx_in;
      dn_idx_ff  <= dn_idx_in;
      on_dist_ff <= on_dist_in;
   end

endmodule

`default_nettype wire

/* src/disk_request_elevator_scheduler.sv */
// Top level of the elevator disk request scheduler: sequencer, head state and
// result register. Depends on desch_pkg, desch_table and desch_select.
//
//   Channel   Ports                          Direction   Beat
//   request   req_valid/req_ready, req_*     in          one store or schedule command
//   response  rsp_valid/rsp_ready, rsp_*     out         one result per command
//
// A store goes from idle straight to the done state. A schedule with N pending
// entries makes one table read per cycle through the compare unit, then one read
// and one write per cycle to close the gap left by the served entry.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A new command is taken while an earlier result waits; a stalled response
// holds the next result inside until the output register frees.
`default_nettype none

module disk_request_elevator_scheduler #(
   parameter int TABLE_DEPTH  = desch_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_CYLINDER = desch_pkg::DEF_MAX_CYLINDER
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire        req_cmd,
   input  wire [7:0]  req_id,
   input  wire [7:0]  req_cylinder,
   input  wire [7:0]  req_track,
   input  wire [7:0]  req_record,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_out_id,
   output logic [7:0] rsp_out_cylinder,
   output logic [7:0] rsp_out_track,
   output logic [7:0] rsp_out_record,
   output logic       rsp_out_direction
);
   import desch_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       head_cyl_ff, head_cyl_in;
   logic [7:0]       head_trk_ff, head_trk_in;
   logic [7:0]       head_rec_ff, head_rec_in;
   logic             sweep_down_ff, sweep_down_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [7:0]       res_id_ff, res_id_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] sh_ptr_ff, sh_ptr_in;
   logic             smp_vld_ff, smp_vld_in;
   logic [IDX_W-1:0] smp_idx_ff, smp_idx_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_id_ff, rsp_id_in;
   logic [7:0]       rsp_cyl_ff, rsp_cyl_in;
   logic [7:0]       rsp_trk_ff, rsp_trk_in;
   logic [7:0]       rsp_rec_ff, rsp_rec_in;
   logic             rsp_dir_ff, rsp_dir_in;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;
   entry_type        new_entry;
   scan_ctl_type     scan_ctl;
   entry_type        pick_entry;
   logic [IDX_W-1:0] pick_idx;
   logic             pick_down;
   logic [CNT_W-1:0] sh_nxt;

   desch_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   desch_select #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_select (
      .clock         (clock),
      .reset         (reset),
      .scan_ctl      (scan_ctl),
      .smp_entry     (mem_rd_data),
      .smp_idx       (smp_idx_ff),
      .head_cylinder (head_cyl_ff),
      .head_track    (head_trk_ff),
      .head_record   (head_rec_ff),
      .sweep_down    (sweep_down_ff),
      .pick_entry    (pick_entry),
      .pick_idx      (pick_idx),
      .pick_down     (pick_down)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign sh_nxt    = sh_ptr_ff + CNT_W'(1);

   always_comb begin
      new_entry.id       = req_id;
      new_entry.cylinder = (32'(req_cylinder) > MAX_CYLINDER) ? 8'(MAX_CYLINDER)
                                                              : req_cylinder;
      new_entry.track    = req_track;
      new_entry.record   = req_record;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_cyl_in   = head_cyl_ff;
      head_trk_in   = head_trk_ff;
      head_rec_in   = head_rec_ff;
      sweep_down_in = sweep_down_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rd_ptr_in     = rd_ptr_ff;
      sh_ptr_in     = sh_ptr_ff;
      smp_vld_in    = smp_vld_ff;
      smp_idx_in    = smp_idx_ff;
      wr_pend_in    = wr_pend_ff;
      wr_idx_in     = wr_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_cyl_in    = rsp_cyl_ff;
      rsp_trk_in    = rsp_trk_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_dir_in    = rsp_dir_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[IDX_W-1:0];
      mem_wr_data   = new_entry;
      mem_rd_addr   = rd_ptr_ff[IDX_W-1:0];
      scan_ctl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_id_in = 8'd0;
               if (req_cmd == CMD_STORE) begin
                  state_in = ST_DONE;
                  if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     mem_wr_en     = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     res_status_in = STATUS_STORED;
                  end
               end else if (count_ff == '0) begin
                  res_status_in = STATUS_EMPTY;
                  state_in      = ST_DONE;
               end else begin
                  scan_ctl.start = 1'b1;
                  rd_ptr_in      = '0;
                  smp_vld_in     = 1'b0;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            scan_ctl.sample = smp_vld_ff;
            smp_vld_in      = 1'b0;
            if (rd_ptr_ff < count_ff) begin
               smp_vld_in = 1'b1;
               smp_idx_in = rd_ptr_ff[IDX_W-1:0];
               rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
            end else if (!smp_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            head_cyl_in   = pick_entry.cylinder;
            head_trk_in   = pick_entry.track;
            head_rec_in   = pick_entry.record;
            sweep_down_in = pick_down;
            res_id_in     = pick_entry.id;
            res_status_in = STATUS_SERVED;
            sh_ptr_in     = CNT_W'(pick_idx);
            wr_pend_in    = 1'b0;
            state_in      = ST_SHIFT;
         end
         ST_SHIFT: begin
            mem_wr_en   = wr_pend_ff;
            mem_wr_addr = wr_idx_ff;
            mem_wr_data = mem_rd_data;
            wr_pend_in  = 1'b0;
            if (sh_nxt < count_ff) begin
               mem_rd_addr = sh_nxt[IDX_W-1:0];
               wr_pend_in  = 1'b1;
               wr_idx_in   = sh_ptr_ff[IDX_W-1:0];
               sh_ptr_in   = sh_nxt;
            end else if (!wr_pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_cyl_in    = head_cyl_ff;
               rsp_trk_in    = head_trk_ff;
               rsp_rec_in    = head_rec_ff;
               rsp_dir_in    = sweep_down_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         head_cyl_ff   <= 8'd0;
         head_trk_ff   <= 8'd0;
         head_rec_ff   <= 8'd0;
         sweep_down_ff <= 1'b0;
         rd_ptr_ff     <= '0;
         sh_ptr_ff     <= '0;
         smp_vld_ff    <= 1'b0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         head_cyl_ff   <= head_cyl_in;
         head_trk_ff   <= head_trk_in;
         head_rec_ff   <= head_rec_in;
         sweep_down_ff <= sweep_down_in;
         rd_ptr_ff     <= rd_ptr_in;
         sh_ptr_ff     <= sh_ptr_in;
         smp_vld_ff    <= smp_vld_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      smp_idx_ff    <= smp_idx_in;
      wr_idx_ff     <= wr_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_cyl_ff    <= rsp_cyl_in;
      rsp_trk_ff    <= rsp_trk_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_dir_ff    <= rsp_dir_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_id        = rsp_id_ff;
   assign rsp_out_cylinder  = rsp_cyl_ff;
   assign rsp_out_track     = rsp_trk_ff;
   assign rsp_out_record    = rsp_rec_ff;
   assign rsp_out_direction = rsp_dir_ff;

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the elevator disk request scheduler.
// A queue-fed driver sends store and schedule beats; a monitor checks every result
// against an in-bench scheduler model. Depends on desch_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module testbench;
   import desch_pkg::*;

   typedef struct {
      logic      cmd;
      entry_type e;
      bit        hold;
   } disk_cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] id;
      logic [7:0] cylinder;
      logic [7:0] track;
      logic [7:0] record;
      logic       direction;
   } sched_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd = 1'b0;
   logic [7:0] req_id = '0;
   logic [7:0] req_cylinder = '0;
   logic [7:0] req_track = '0;
   logic [7:0] req_record = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [7:0] rsp_out_id;
   logic [7:0] rsp_out_cylinder;
   logic [7:0] rsp_out_track;
   logic [7:0] rsp_out_record;
   logic       rsp_out_direction;

   disk_cmd_type     pending_cmds[$];
   disk_cmd_type     driven;
   sched_result_type awaiting_results[$];
   sched_result_type got;
   sched_result_type want;

   entry_type  pending_requests[$];
   entry_type  head = '0;
   logic       sweep_down = 1'b0;

   int         beats_sent = 0;
   int         beats_answered = 0;
   int         mismatches = 0;
   int         idle_left = 0;
   int         stall_left = 0;
   bit         took_req;
   logic [11:0] cycle_no = '0;
   wire        quiet_phase = (cycle_no[11:10] == 2'b00);

   int fill_cyl [16] = '{0, 0, 255, 200, 199, 50, 20, 80, 20, 120, 7, 199, 198, 1, 100, 50};

   disk_request_elevator_scheduler DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_id(req_id),
      .req_cylinder(req_cylinder),
      .req_track(req_track),
      .req_record(req_record),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_out_id(rsp_out_id),
      .rsp_out_cylinder(rsp_out_cylinder),
      .rsp_out_track(rsp_out_track),
      .rsp_out_record(rsp_out_record),
      .rsp_out_direction(rsp_out_direction)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1'b1;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Nearest pending cylinder strictly ahead of the head in the given direction.
   function automatic int nearest_ahead(input logic down);
      int best;
      logic [7:0] c;
      best = -1;
      for (int i = 0; i < pending_requests.size(); i++) begin
         c = pending_requests[i].cylinder;
         if ((down ? c < head.cylinder : c > head.cylinder) &&
             (best < 0 || (down ? c > pending_requests[best].cylinder
                                : c < pending_requests[best].cylinder)))
            best = i;
      end
      return best;
   endfunction

   task automatic elevator_step(input disk_cmd_type c);
      sched_result_type r;
      entry_type e;
      int pick;
      int d;
      int best_d;
      r = '0;
      if (c.cmd == CMD_STORE) begin
         if (pending_requests.size() >= DEF_TABLE_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            e = c.e;
            if (e.cylinder > DEF_MAX_CYLINDER) e.cylinder = 8'(DEF_MAX_CYLINDER);
            pending_requests.push_back(e);
            r.status = STATUS_STORED;
         end
      end else if (pending_requests.size() == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         pick = -1;
         best_d = 0;
         for (int i = 0; i < pending_requests.size(); i++) begin
            if (pending_requests[i].cylinder == head.cylinder) begin
               d = ((pending_requests[i].track > head.track)
                       ? int'(pending_requests[i].track) - int'(head.track)
                       : int'(head.track) - int'(pending_requests[i].track))
                 + ((pending_requests[i].record > head.record)
                       ? int'(pending_requests[i].record) - int'(head.record)
                       : int'(head.record) - int'(pending_requests[i].record));
               if (pick < 0 || d < best_d) begin
                  pick = i;
                  best_d = d;
               end
            end
         end
         if (pick < 0) begin
            pick = nearest_ahead(sweep_down);
            if (pick < 0) begin
               sweep_down = ~sweep_down;
               pick = nearest_ahead(sweep_down);
            end
         end
         r.id = pending_requests[pick].id;
         head = pending_requests[pick];
         pending_requests.delete(pick);
         r.status = STATUS_SERVED;
      end
      r.cylinder = head.cylinder;
      r.track = head.track;
      r.record = head.record;
      r.direction = sweep_down;
      awaiting_results.push_back(r);
   endtask

   task automatic add_cmd(input logic cmd, input logic [7:0] id, input logic [7:0] cyl,
                          input logic [7:0] trk, input logic [7:0] rec, input bit hold);
      disk_cmd_type c;
      c.cmd = cmd;
      c.e.id = id;
      c.e.cylinder = cyl;
      c.e.track = trk;
      c.e.record = rec;
      c.hold = hold;
      pending_cmds.push_back(c);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else begin
         took_req = req_valid && req_ready;
         if (took_req) begin
            elevator_step(driven);
            beats_sent <= beats_sent + 1;
            idle_left = quiet_phase ? 0 : idle_length();
         end
         if (!req_valid || req_ready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0 && (!pending_cmds[0].hold ||
                         (!took_req && beats_sent == beats_answered))) begin
               driven = pending_cmds.pop_front();
               req_valid <= 1'b1;
               req_cmd <= driven.cmd;
               req_id <= driven.e.id;
               req_cylinder <= driven.e.cylinder;
               req_track <= driven.e.track;
               req_record <= driven.e.record;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_out_id, rsp_out_cylinder, rsp_out_track,
                   rsp_out_record, rsp_out_direction};
            beats_answered <= beats_answered + 1;
            if (awaiting_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result beat: status %0d id %0d cyl %0d",
                           got.status, got.id, got.cylinder);
            end else begin
               want = awaiting_results.pop_front();
               if (got.status !== want.status || got.id !== want.id ||
                   got.cylinder !== want.cylinder || got.track !== want.track ||
                   got.record !== want.record || got.direction !== want.direction) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected st %0d id %0d cyl %0d trk %0d rec %0d dir %0d,",
                              want.status, want.id, want.cylinder, want.track,
                              want.record, want.direction,
                              " got st %0d id %0d cyl %0d trk %0d rec %0d dir %0d",
                              got.status, got.id, got.cylinder, got.track,
                              got.record, got.direction);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            stall_left = idle_length();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [7:0] cyl_pool[4];
      int kind;
      int len;
      int n;
      int r;
      logic cmd;
      logic [7:0] cyl;
      logic [7:0] trk;
      logic [7:0] rec;

      add_cmd(CMD_SCHED, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      for (int i = 0; i < 16; i++)
         add_cmd(CMD_STORE, 8'(i * 17), 8'(fill_cyl[i]), 8'(i * 23), 8'(255 - i * 29), 1'b0);
      add_cmd(CMD_STORE, 8'hFF, 8'd99, 8'hFF, 8'h00, 1'b0);
      add_cmd(CMD_SCHED, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
      for (int i = 0; i < 6; i++)
         add_cmd(CMD_SCHED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);

      n = 0;
      while (n < 925) begin
         kind = $urandom_range(0, 3);
         len = $urandom_range(4, 30);
         for (int k = 0; k < 4; k++) begin
            r = $urandom_range(0, 9);
            cyl_pool[k] = (r == 0) ? 8'd0 : (r == 1) ? 8'd199 :
                          (r == 2) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 199));
         end
         for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 9);
            case (kind)
               0: cmd = (r < 8) ? CMD_STORE : CMD_SCHED;
               1: cmd = (r < 2) ? CMD_STORE : CMD_SCHED;
               2: cmd = (r < 5) ? CMD_STORE : CMD_SCHED;
               default: cmd = r[0] ? CMD_SCHED : CMD_STORE;
            endcase
            if (kind != 3 && $urandom_range(0, 9) < 7)
               cyl = cyl_pool[$urandom_range(0, 3)];
            else
               cyl = 8'($urandom);
            trk = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            rec = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            add_cmd(cmd, 8'($urandom), cyl, trk, rec, (n % 190) == 0);
            n++;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_valid || beats_sent != beats_answered)
         @(negedge clock);
      repeat (60) @(posedge clock);

      if (mismatches == 0 && awaiting_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #6ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
